>>> rtl/cfa_pkg.sv
// Types and constants shared by the contiguous frame allocator modules.
// No dependencies.
`default_nettype none
package cfa_pkg;

   localparam int FRAME_W = 20;
   localparam int COUNT_W = 15;
   localparam int STAT_W  = 3;
   localparam int CSR_IW  = 2;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_MARK    = 2'd2,
      OP_INIT    = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK          = 3'd0,
      ST_NO_RUN      = 3'd1,
      ST_NOT_HEAD    = 3'd2,
      ST_OUT_OF_POOL = 3'd3,
      ST_BAD_COUNT   = 3'd4
   } status_type;

   localparam logic [CSR_IW-1:0] CSR_BASE_FRAME    = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_POOL_SIZE     = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_RESERVE_FIRST = 2'd2;

   localparam logic [1:0] FR_FREE = 2'b00;
   localparam logic [1:0] FR_USED = 2'b01;
   localparam logic [1:0] FR_HEAD = 2'b11;

   typedef struct packed {
      op_type              op;
      logic [FRAME_W-1:0]  frame_number;
      logic [COUNT_W-1:0]  count;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0]  result_frame;
      status_type          status;
      logic [COUNT_W-1:0]  free_frames;
   } rsp_type;

   typedef struct packed {
      op_type              kind;
      logic                early;
      status_type          status;
      logic [FRAME_W-1:0]  offset;
      logic [COUNT_W-1:0]  count;
   } cmd_type;

endpackage
`default_nettype wire

>>> rtl/contiguous_frame_allocator_core.sv
// Top level of the contiguous frame allocator: configuration registers,
// front end and back end. Depends on cfa_pkg, cfa_front and cfa_back.
//
//   port group   direction  handshake            payload
//   req_         in         req_valid/req_ready  req_type (op, frame_number, count)
//   rsp_         out        rsp_valid/rsp_ready  rsp_type (result_frame, status, free_frames)
//   csr_         in         csr_write            csr_index, csr_wdata
//
// The back end works through the frame map four frames per memory word.
// Allocate scans the map word by word, then reads and writes back each word it
// marks; release and mark read and write back each word touched; init rewrites
// every word. After reset a clearing pass over every word runs, during which no
// request transfer is taken. A two-entry queue and an output register let
// requests be taken while a result waits.
`default_nettype none
module contiguous_frame_allocator_core
   import cfa_pkg::*;
#(
   parameter int MAX_FRAMES = 16384
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_payload,
   input  wire logic               csr_write,
   input  wire logic [CSR_IW-1:0]  csr_index,
   input  wire logic [FRAME_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_FRAMES + 1);
   localparam int SW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [FRAME_W-1:0] base_ff;
   logic [COUNT_W-1:0] pool_ff;
   logic               resv_ff;
   logic [SW-1:0]      pool_ext;
   logic [CW-1:0]      pool_frames;
   logic               clearing;
   logic               cmd_valid;
   logic               cmd_pop;
   cmd_type            cmd;

   assign pool_ext    = SW'(pool_ff);
   assign pool_frames = (pool_ext < SW'(MAX_FRAMES)) ? CW'(pool_ext) : CW'(MAX_FRAMES);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         pool_ff <= COUNT_W'(16384);
         resv_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BASE_FRAME:    base_ff <= csr_wdata;
            CSR_POOL_SIZE:     pool_ff <= csr_wdata[COUNT_W-1:0];
            CSR_RESERVE_FIRST: resv_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   cfa_front #(
      .CW (CW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .clearing    (clearing),
      .base_frame  (base_ff),
      .pool_frames (pool_frames),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   cfa_back #(
      .MAX_FRAMES (MAX_FRAMES),
      .CW         (CW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .clearing      (clearing),
      .base_frame    (base_ff),
      .pool_frames   (pool_frames),
      .reserve_first (resv_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

   a_no_transfer_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("request taken during clearing pass");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_failed_result_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_OK) |-> (rsp_payload.result_frame == '0))
      else $error("failed operation returned a frame");

endmodule
`default_nettype wire

>>> rtl/cfa_front.sv
// Front end: accepts requests, checks their count and their place in the pool and queues commands.
// Depends on cfa_pkg.
`default_nettype none
module cfa_front
   import cfa_pkg::*;
#(
   parameter int CW = 15
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_payload,
   input  wire logic               clearing,
   input  wire logic [FRAME_W-1:0] base_frame,
   input  wire logic [CW-1:0]      pool_frames,
   output logic                    cmd_valid,
   output cmd_type                 cmd,
   input  wire logic               cmd_pop
);

   cmd_type           queue_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push;
   cmd_type           entry;
   logic [FRAME_W:0]  diff;
   logic [FRAME_W-1:0] n_ext;
   logic              outside;

   assign req_ready = (fill_ff != 2'd2) && !clearing;
   assign push      = req_valid && req_ready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      diff    = {1'b0, req_payload.frame_number} - {1'b0, base_frame};
      n_ext   = FRAME_W'(pool_frames);
      outside = diff[FRAME_W] || (diff[FRAME_W-1:0] >= n_ext);
      entry.kind   = req_payload.op;
      entry.early  = 1'b0;
      entry.status = ST_OK;
      entry.offset = diff[FRAME_W-1:0];
      entry.count  = req_payload.count;
      unique case (req_payload.op)
         OP_ALLOC: begin
            if (req_payload.count == '0) begin
               entry.early  = 1'b1;
               entry.status = ST_BAD_COUNT;
            end
         end
         OP_RELEASE: begin
            if (outside) begin
               entry.early  = 1'b1;
               entry.status = ST_OUT_OF_POOL;
            end
         end
         OP_MARK: begin
            if (req_payload.count == '0) begin
               entry.early  = 1'b1;
               entry.status = ST_BAD_COUNT;
            end else if (outside ||
                         (FRAME_W'(req_payload.count) > n_ext - diff[FRAME_W-1:0])) begin
               entry.early  = 1'b1;
               entry.status = ST_OUT_OF_POOL;
            end
         end
         OP_INIT: begin
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/cfa_back.sv
// Back end: owns the frame map memory and the free count, and executes commands.
// Depends on cfa_pkg.
`default_nettype none
module cfa_back
   import cfa_pkg::*;
#(
   parameter int MAX_FRAMES = 16384,
   parameter int CW         = 15
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire cmd_type            cmd,
   output logic                    cmd_pop,
   output logic                    clearing,
   input  wire logic [FRAME_W-1:0] base_frame,
   input  wire logic [CW-1:0]      pool_frames,
   input  wire logic               reserve_first,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_payload
);

   localparam int WORDS = MAX_FRAMES / 4;
   localparam int WAW   = $clog2(WORDS);
   localparam int PW    = CW - 2;
   localparam int CW1   = CW + 1;
   localparam int SW    = (CW > COUNT_W) ? CW : COUNT_W;

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_SCAN, S_MOD_RD, S_MOD_WR, S_RESP
   } state_type;

   logic [7:0]     mem [WORDS];
   logic [7:0]     rdata_ff;
   logic           rd_en;
   logic           we;
   logic [WAW-1:0] wa;
   logic [7:0]     wd;

   state_type      state_ff, state_in;
   op_type         kind_ff, kind_in;
   status_type     st_ff, st_in;
   logic [CW-1:0]  lo_ff, lo_in, hi_ff, hi_in, cnt_ff, cnt_in, fc_ff, fc_in, run_ff, run_in;
   logic [PW-1:0]  cur_ff, cur_in, pword_ff, pword_in;
   logic           pend_ff, pend_in, go_ff, go_in, init_ff, init_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic [CW-1:0]  idx;
   logic [1:0]     code;
   logic [CW-1:0]  sidx;
   logic [1:0]     scode;
   logic [CW-1:0]  run_v, start_v, next_base;
   logic           found, can_issue, go_v, bad;
   logic [2:0]     k;
   logic [7:0]     wd_v;
   logic [CW:0]    sum;
   logic           rel;

   assign clearing    = (state_ff == S_CLR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign cmd_pop     = (state_ff == S_IDLE) && cmd_valid;
   assign rel         = (kind_ff == OP_RELEASE);
   assign next_base   = {cur_ff + PW'(1), 2'b00};
   assign can_issue   = ({cur_ff, 2'b00} < pool_frames);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rdata_ff <= mem[cur_ff[WAW-1:0]];
      end
   end

   always_comb begin
      run_v   = run_ff;
      found   = 1'b0;
      start_v = '0;
      sidx    = '0;
      scode   = '0;
      for (int j = 0; j < 4; j++) begin
         sidx  = {pword_ff, 2'(j)};
         scode = rdata_ff[2*j +: 2];
         if (pend_ff && !found && sidx < pool_frames) begin
            if (scode != FR_USED && scode != FR_HEAD) begin
               run_v = run_v + CW'(1);
               if (run_v == cnt_ff) begin
                  found   = 1'b1;
                  start_v = sidx + CW'(1) - cnt_ff;
               end
            end else begin
               run_v = '0;
            end
         end
      end
   end

   always_comb begin
      go_v = go_ff;
      bad  = 1'b0;
      k    = '0;
      wd_v = rdata_ff;
      idx  = '0;
      code = '0;
      for (int j = 0; j < 4; j++) begin
         idx  = {cur_ff, 2'(j)};
         code = rdata_ff[2*j +: 2];
         if (rel) begin
            if (idx == lo_ff) begin
               if (code != FR_HEAD) begin
                  bad = 1'b1;
               end else begin
                  wd_v[2*j +: 2] = FR_FREE;
                  k = k + 3'd1;
               end
            end else if (idx > lo_ff) begin
               if (go_v && idx < hi_ff && code == FR_USED) begin
                  wd_v[2*j +: 2] = FR_FREE;
                  k = k + 3'd1;
               end else begin
                  go_v = 1'b0;
               end
            end
         end else if (idx >= lo_ff && idx < hi_ff) begin
            if (code != FR_USED && code != FR_HEAD) begin
               k = k + 3'd1;
            end
            wd_v[2*j +: 2] = (idx == lo_ff) ? FR_HEAD : FR_USED;
         end
      end
      sum = {1'b0, fc_ff} + CW1'(k);
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      st_in        = st_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cnt_in       = cnt_ff;
      fc_in        = fc_ff;
      run_in       = run_ff;
      cur_in       = cur_ff;
      pword_in     = pword_ff;
      pend_in      = pend_ff;
      go_in        = go_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      we           = 1'b0;
      wa           = cur_ff[WAW-1:0];
      wd           = '0;
      unique case (state_ff)
         S_CLR: begin
            we = 1'b1;
            if (init_ff && reserve_first && pool_frames != '0 && cur_ff == '0) begin
               wd = {6'b0, FR_USED};
            end
            cur_in = cur_ff + PW'(1);
            if (cur_ff == PW'(WORDS - 1)) begin
               if (init_ff) begin
                  fc_in    = pool_frames -
                             CW'(reserve_first && pool_frames != '0);
                  st_in    = ST_OK;
                  state_in = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               kind_in = cmd.kind;
               st_in   = cmd.status;
               lo_in   = CW'(cmd.offset);
               cnt_in  = CW'(cmd.count);
               cur_in  = cmd.offset[CW-1:2];
               go_in   = 1'b1;
               run_in  = '0;
               pend_in = 1'b0;
               if (cmd.early) begin
                  state_in = S_RESP;
               end else begin
                  unique case (cmd.kind)
                     OP_INIT: begin
                        init_in  = 1'b1;
                        cur_in   = '0;
                        state_in = S_CLR;
                     end
                     OP_ALLOC: begin
                        cur_in = '0;
                        if (SW'(cmd.count) > SW'(fc_ff)) begin
                           st_in    = ST_NO_RUN;
                           state_in = S_RESP;
                        end else begin
                           state_in = S_SCAN;
                        end
                     end
                     OP_RELEASE: begin
                        hi_in    = pool_frames;
                        state_in = S_MOD_RD;
                     end
                     OP_MARK: begin
                        hi_in    = CW'(cmd.offset) + CW'(cmd.count);
                        state_in = S_MOD_RD;
                     end
                  endcase
               end
            end
         end
         S_SCAN: begin
            run_in   = run_v;
            rd_en    = can_issue && !found;
            pend_in  = can_issue && !found;
            pword_in = cur_ff;
            cur_in   = cur_ff + PW'(1);
            if (found) begin
               lo_in    = start_v;
               hi_in    = start_v + cnt_ff;
               cur_in   = start_v[CW-1:2];
               state_in = S_MOD_RD;
            end else if (!pend_ff && !can_issue) begin
               st_in    = ST_NO_RUN;
               state_in = S_RESP;
            end
         end
         S_MOD_RD: begin
            rd_en    = 1'b1;
            state_in = S_MOD_WR;
         end
         S_MOD_WR: begin
            we    = !bad;
            wd    = wd_v;
            go_in = go_v;
            if (!bad) begin
               if (rel) begin
                  fc_in = (sum > CW1'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : sum[CW-1:0];
               end else begin
                  fc_in = (fc_ff > CW'(k)) ? fc_ff - CW'(k) : '0;
               end
            end
            cur_in = cur_ff + PW'(1);
            if (!bad && (!rel || go_v) && next_base < hi_ff) begin
               state_in = S_MOD_RD;
            end else begin
               st_in    = bad ? ST_NOT_HEAD : ST_OK;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_frame = (kind_ff == OP_ALLOC && st_ff == ST_OK) ?
                                     base_frame + FRAME_W'(lo_ff) : '0;
               rsp_in.status       = st_ff;
               rsp_in.free_frames  = COUNT_W'(fc_ff);
               init_in             = 1'b0;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      st_ff    <= st_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      cnt_ff   <= cnt_in;
      run_ff   <= run_in;
      pword_ff <= pword_in;
      go_ff    <= go_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_CLR;
         cur_ff       <= '0;
         fc_ff        <= '0;
         pend_ff      <= 1'b0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         fc_ff        <= fc_in;
         pend_ff      <= pend_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire
